@@ design/zics_pkg.sv @@
// Shared constants, field widths and types for the Zipf inverse-CDF sampler.
// No dependencies; imported by every module except zics_cdf_ram.
package zics_pkg;

	localparam int TABLE_DEPTH   = 1024;
	localparam int FRACTION_BITS = 32;

	localparam int ENTRY_W    = FRACTION_BITS + 1;
	localparam int IDX_W      = $clog2(TABLE_DEPTH);
	localparam int COUNT_W    = $clog2(TABLE_DEPTH + 1);
	localparam int INDEX_IN_W = 10;
	localparam int RANK_W     = 11;
	localparam int CALC_W     = (COUNT_W > RANK_W) ? COUNT_W : RANK_W;

	localparam int TDATA_IN_W  = ((INDEX_IN_W + ENTRY_W + FRACTION_BITS + 7) / 8) * 8;
	localparam int TDATA_OUT_W = ((RANK_W + 7) / 8) * 8;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef struct packed {
		logic               we;
		logic [IDX_W-1:0]   addr;
		logic [ENTRY_W-1:0] wdata;
	} ram_req_t;

endpackage

@@ design/zics_cdf_ram.sv @@
// Single-port synchronous RAM holding the cumulative table, registered read.
// Generic; no package dependency.
module zics_cdf_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 33
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ design/zics_search.sv @@
// Transfer control, binary-search sequencer and output register.
// Depends on zics_pkg; drives the table RAM through a ram_req_t.
module zics_search (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [zics_pkg::RANK_W-1:0]        num_ranks,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               in_action,
	input  logic [zics_pkg::INDEX_IN_W-1:0]    in_index,
	input  logic [zics_pkg::ENTRY_W-1:0]       in_value,
	input  logic [zics_pkg::FRACTION_BITS-1:0] in_uniform,
	output zics_pkg::ram_req_t                 ram_req,
	input  logic [zics_pkg::ENTRY_W-1:0]       ram_rdata,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [zics_pkg::RANK_W-1:0]        out_rank
);
	import zics_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_HOLD   = 3'b100
	} state_t;

	state_t                   state_q, state_d;
	logic [COUNT_W-1:0]       lo_q, lo_d;
	logic [COUNT_W-1:0]       count_q, count_d;
	logic [COUNT_W-1:0]       step_q, step_d;
	logic [IDX_W-1:0]         mid_q, mid_d;
	logic [COUNT_W-1:0]       n_q;
	logic [FRACTION_BITS-1:0] uniform_q;
	logic [RANK_W-1:0]        hold_q, rank_d;
	logic                     out_valid_q;
	logic [RANK_W-1:0]        out_rank_q;
	logic                     out_load;
	logic                     out_free;
	logic [COUNT_W-1:0]       n_use;
	logic [COUNT_W-1:0]       lo_plus;
	logic                     in_xfer;
	logic                     below;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_rank  = out_rank_q;
	assign below     = ram_rdata < {1'b0, uniform_q};

	always_comb begin
		if (num_ranks == '0) begin
			n_use = COUNT_W'(1);
		end else if (CALC_W'(num_ranks) > CALC_W'(TABLE_DEPTH)) begin
			n_use = COUNT_W'(TABLE_DEPTH);
		end else begin
			n_use = COUNT_W'(num_ranks);
		end
	end

	always_comb begin
		state_d       = state_q;
		lo_d          = lo_q;
		count_d       = count_q;
		step_d        = step_q;
		mid_d         = mid_q;
		rank_d        = hold_q;
		lo_plus       = '0;
		out_load      = 1'b0;
		ram_req.we    = 1'b0;
		ram_req.addr  = IDX_W'(in_index);
		ram_req.wdata = in_value;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (in_action == ACT_WRITE) begin
						ram_req.we = (int'(in_index) < TABLE_DEPTH);
					end else begin
						lo_d         = '0;
						count_d      = n_use;
						step_d       = n_use >> 1;
						mid_d        = IDX_W'(n_use >> 1);
						ram_req.addr = mid_d;
						state_d      = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				if (below) begin
					lo_d    = COUNT_W'(mid_q) + COUNT_W'(1);
					count_d = count_q - step_q - COUNT_W'(1);
				end else begin
					count_d = step_q;
				end
				step_d       = count_d >> 1;
				mid_d        = IDX_W'(lo_d + step_d);
				ram_req.addr = mid_d;
				if (count_d == '0) begin
					lo_plus = lo_d + COUNT_W'(1);
					rank_d  = (lo_plus < n_q) ? RANK_W'(lo_plus) : RANK_W'(n_q);
					if (out_free) begin
						out_load = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						state_d  = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q    <= lo_d;
		count_q <= count_d;
		step_q  <= step_d;
		mid_q   <= mid_d;
		hold_q  <= rank_d;
		if (in_xfer) begin
			n_q       <= n_use;
			uniform_q <= in_uniform;
		end
		if (out_load) begin
			out_rank_q <= rank_d;
		end
	end

endmodule

@@ design/zipf_inverse_cdf_sampler_top.sv @@
// Zipf inverse-CDF sampler, top level.
// Depends on zics_pkg, zics_cdf_ram and zics_search.
//
// Input stream s_axis: tuser selects the kind of transfer. A write transfer
// (tuser 0) stores entry_value at entry_index of the cumulative table and
// gives no result. A sample transfer (tuser 1) carries a Q0.32 uniform
// value; the block binary-searches the first num_ranks entries and returns
// the one-based rank on m_axis.
// Each probe of a sample is one registered RAM read and compare; n ranks
// in use need floor(log2(n)) or floor(log2(n)) + 1 probes, depending on
// the path taken, so at most 11 at 1024.
// m_axis tvalid is registered from the last probe, or from the hold state
// once the output is free; s_axis tready rises with it. A sample must finish
// before the next item is taken; write transfers can be taken back to back.
// cfg_wr_en/cfg_wr_data write num_ranks; write it only while idle.
// Reset sets num_ranks to 1 and empties the output register; the table is
// not cleared and each entry must be written before a sample probes it.
// If m_axis stalls, the result is held in the output register and write
// transfers are still taken; a finished second sample waits in the sequencer.
module zipf_inverse_cdf_sampler_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [zics_pkg::RANK_W-1:0]      cfg_wr_data,   // num_ranks
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// entry_index, entry_value, uniform, zero fill
	input  logic [zics_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
	input  logic [0:0]                       s_axis_tuser,  // action
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [zics_pkg::TDATA_OUT_W-1:0] m_axis_tdata   // rank, zero fill
);
	import zics_pkg::*;

	localparam int VALUE_LSB   = INDEX_IN_W;
	localparam int UNIFORM_LSB = INDEX_IN_W + ENTRY_W;

	logic [RANK_W-1:0]        num_ranks_q;
	logic [INDEX_IN_W-1:0]    entry_index;
	logic [ENTRY_W-1:0]       entry_value;
	logic [FRACTION_BITS-1:0] uniform;
	logic [ENTRY_W-1:0]       ram_rdata;
	logic [RANK_W-1:0]        rank;
	ram_req_t                 ram_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ranks_q <= RANK_W'(1);
		end else if (cfg_wr_en) begin
			num_ranks_q <= cfg_wr_data;
		end
	end

	assign entry_index  = s_axis_tdata[INDEX_IN_W-1:0];
	assign entry_value  = s_axis_tdata[VALUE_LSB +: ENTRY_W];
	assign uniform      = s_axis_tdata[UNIFORM_LSB +: FRACTION_BITS];
	assign m_axis_tdata = TDATA_OUT_W'(rank);

	zics_cdf_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.addr  (ram_req.addr),
		.wdata (ram_req.wdata),
		.rdata (ram_rdata)
	);

	zics_search u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.num_ranks  (num_ranks_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_action  (s_axis_tuser[0]),
		.in_index   (entry_index),
		.in_value   (entry_value),
		.in_uniform (uniform),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_rank   (rank)
	);

endmodule

@@ design/zics_checker.sv @@
// Port-level checks for the Zipf inverse-CDF sampler, bound to the top level.
// Depends on zics_pkg and zipf_inverse_cdf_sampler_top.
module zics_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [0:0]                       s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [zics_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);
	import zics_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_rank_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[RANK_W-1:0] != '0)
		else $error("rank of zero");

	a_rank_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> int'(m_axis_tdata[RANK_W-1:0]) <= TABLE_DEPTH)
		else $error("rank above table depth");

	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == ACT_SAMPLE |=> !s_axis_tready)
		else $error("input taken during search");

endmodule

bind zipf_inverse_cdf_sampler_top zics_checker u_zics_checker (.*);
